### rtl/core/ukvt_pkg.sv
// shared types and constants of the unsorted key/value table
package ukvt_pkg;

  // fixed field widths of the stream items
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CAP_W    = 5;

  // packed stream widths
  localparam int unsigned S_TDATA_W = KEY_W + VALUE_W;
  localparam int unsigned M_TDATA_W = 48;

  // default table depth and capacity after reset
  localparam int unsigned DEF_TABLE_DEPTH = 16;
  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

  // operation codes, any code with the high bit set is a find
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam int unsigned       MODE_FIND_BIT = 1;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [S_TDATA_W-1:0] s_tdata_t;
  typedef logic [M_TDATA_W-1:0] m_tdata_t;
  typedef logic [CAP_W-1:0]     cap_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_FULL  = 3'd1,
    STAT_DUP   = 3'd2,
    STAT_EMPTY = 3'd3,
    STAT_MISS  = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_LAST_RD,
    S_MOVE,
    S_RESULT
  } state_e;

endpackage

### rtl/core/unsorted_key_value_table_core.sv
// Unsorted key/value table: one shared key comparator walks the stored entries.
// From accept to result valid: a full insert or an empty remove goes straight to the result state,
// else the search walks the stored entries until a hit or the end; a remove that hits then reads
// the last entry and moves it into the freed slot; the result register is then loaded.
// Throughput: one item at a time; a held result stalls the sequencer.
// Reset: count clears, capacity returns to 16, no result pending, table memory not cleared.
module unsorted_key_value_table_core #(
  parameter int unsigned TABLE_DEPTH = ukvt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  ukvt_pkg::cap_t      cfg_data_i,   // capacity_limit
  // input items
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ukvt_pkg::s_tdata_t  s_tdata,      // key[31:0], value[63:32]
  input  ukvt_pkg::mode_t     s_tuser,      // mode[1:0]
  // result items
  output logic                m_tvalid,
  input  logic                m_tready,
  output ukvt_pkg::m_tdata_t  m_tdata,      // found_value[31:0], found_slot[35:32],
                                            // entry_count[40:36], is_full[41], is_empty[42]
  output logic [ukvt_pkg::STATUS_W-1:0] m_tuser  // status[2:0]
);
  import ukvt_pkg::*;

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  // sequencer and item registers
  state_e              state_q, state_d;
  mode_t               mode_q, mode_d;
  key_t                key_q, key_d;
  value_t              value_q, value_d;
  cap_t                cap_q;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_idx_q, pend_idx_d;
  logic [AW-1:0]       slot_q, slot_d;
  status_e             res_status_q, res_status_d;
  value_t              res_value_q, res_value_d;

  // table memory
  key_t                key_mem [TABLE_DEPTH];
  value_t              val_mem [TABLE_DEPTH];
  logic [AW-1:0]       rd_addr;
  key_t                key_rd_q;
  value_t              val_rd_q;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  key_t                wr_key;
  value_t              wr_val;

  // output register
  logic                m_tvalid_q, m_tvalid_d;
  status_e             out_status_q;
  value_t              out_value_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_full_q, out_empty_q;
  logic                out_load;

  // shared decode
  logic                accept, issue, hit, search_done, out_free, full_now, empty_now;
  logic                is_find, is_insert;
  logic [CW-1:0]       last_idx;

  assign cfg_ready_o = 1'b1;
  assign s_tready    = (state_q == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid_q || m_tready;
  assign is_find     = mode_q[MODE_FIND_BIT];
  assign is_insert   = (mode_q == MODE_INSERT);
  assign issue       = (idx_q < count_q);
  assign hit         = pend_q && (key_rd_q == key_q);
  assign search_done = !pend_q && !issue;
  assign last_idx    = count_q - CW'(1);
  assign empty_now   = (count_q == '0);
  assign full_now    = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(TABLE_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_tuser[MODE_FIND_BIT]) begin
            state_d = S_SEARCH;
          end else if (s_tuser == MODE_INSERT) begin
            state_d = full_now ? S_RESULT : S_SEARCH;
          end else begin
            state_d = empty_now ? S_RESULT : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = (is_find || is_insert) ? S_RESULT : S_LAST_RD;
        end else if (search_done) begin
          state_d = S_RESULT;
        end
      end
      S_LAST_RD: state_d = S_MOVE;
      S_MOVE:    state_d = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rd_addr      = idx_q[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = count_q[AW-1:0];
    wr_key       = key_q;
    wr_val       = value_q;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d       = s_tuser;
          key_d        = s_tdata[KEY_W-1:0];
          value_d      = s_tdata[KEY_W +: VALUE_W];
          idx_d        = '0;
          pend_d       = 1'b0;
          slot_d       = '0;
          res_value_d  = '0;
          res_status_d = STAT_OK;
          if (!s_tuser[MODE_FIND_BIT]) begin
            if (s_tuser == MODE_INSERT && full_now) begin
              res_status_d = STAT_FULL;
            end else if (s_tuser == MODE_REMOVE && empty_now) begin
              res_status_d = STAT_EMPTY;
            end
          end
        end
      end
      // one read issued and one key compared per cycle
      S_SEARCH: begin
        pend_d     = issue;
        pend_idx_d = idx_q[AW-1:0];
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (hit) begin
          slot_d = pend_idx_q;
          if (is_find) begin
            res_value_d = val_rd_q;
          end else if (is_insert) begin
            res_status_d = STAT_DUP;
          end
        end else if (search_done) begin
          if (is_insert) begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end else begin
            res_status_d = STAT_MISS;
          end
        end
      end
      S_LAST_RD: begin
        rd_addr = last_idx[AW-1:0];
      end
      // last entry fills the freed slot
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_key  = key_rd_q;
        wr_val  = val_rd_q;
        count_d = last_idx;
      end
      S_RESULT: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // output valid
  always_comb begin
    m_tvalid_d = m_tvalid_q;
    if (out_load) begin
      m_tvalid_d = 1'b1;
    end else if (m_tready) begin
      m_tvalid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      cap_q      <= CAP_RESET;
      pend_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_q     <= pend_d;
      m_tvalid_q <= m_tvalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // item and scratch registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    pend_idx_q   <= pend_idx_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
  end

  // key and value memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_slot_q   <= (is_find && res_status_q == STAT_OK) ? SLOT_W'(slot_q) : '0;
      out_count_q  <= COUNT_W'(count_q);
      out_full_q   <= full_now;
      out_empty_q  <= empty_now;
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tuser  = out_status_q;
  assign m_tdata  = M_TDATA_W'({out_empty_q, out_full_q, out_count_q, out_slot_q, out_value_q});

endmodule

### sim/tb_top.sv
// self-checking testbench for the unsorted key/value table core
`timescale 1ns / 100ps

module tb_top;
  import ukvt_pkg::*;

  localparam int unsigned DEPTH         = DEF_TABLE_DEPTH;
  localparam int          NO_SLOT       = -1;
  localparam int unsigned IDLE_PCT      = 7;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned KEY_POOL      = 24;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned TIMEOUT_NS    = 1000000;

  // find codes, the unused code acts as a find
  localparam mode_t MODE_FIND     = 2'd2;
  localparam mode_t MODE_FIND_ALT = 2'd3;

  typedef struct packed {
    status_e                 status;
    value_t                  found_value;
    logic [SLOT_W-1:0]       found_slot;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_full;
    logic                    is_empty;
  } response_t;

  // mirror of the table contents plus the queue of responses still owed
  class table_mirror;
    key_t         keys[DEPTH];
    value_t       vals[DEPTH];
    int unsigned  count;
    cap_t         capacity;
    response_t    expected_responses[$];
    int unsigned  errors;
    int unsigned  requests;
    int unsigned  responses;
    int unsigned  status_seen[8];

    function new();
      count    = 0;
      capacity = CAP_RESET;
      errors   = 0;
      requests = 0;
      responses = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_capacity(cap_t cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction

    // linear search over the occupied slots
    function int find_slot(key_t key);
      for (int i = 0; i < int'(count); i++) begin
        if (keys[i] == key) return i;
      end
      return NO_SLOT;
    endfunction

    // apply one accepted request and queue the response it must produce
    function void apply_request(mode_t mode, key_t key, value_t value);
      response_t   rsp;
      int          slot;
      int unsigned limit;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      rsp = '0;
      rsp.status = STAT_OK;
      slot = find_slot(key);
      if (mode[MODE_FIND_BIT]) begin
        if (slot != NO_SLOT) begin
          rsp.found_value = vals[slot];
          rsp.found_slot  = slot[SLOT_W-1:0];
        end else begin
          rsp.status = STAT_MISS;
        end
      end else if (mode == MODE_INSERT) begin
        if (count >= limit) begin
          rsp.status = STAT_FULL;
        end else if (slot != NO_SLOT) begin
          rsp.status = STAT_DUP;
        end else begin
          keys[count] = key;
          vals[count] = value;
          count++;
        end
      end else begin
        if (count == 0) begin
          rsp.status = STAT_EMPTY;
        end else if (slot == NO_SLOT) begin
          rsp.status = STAT_MISS;
        end else begin
          // last entry fills the freed slot
          keys[slot] = keys[count-1];
          vals[slot] = vals[count-1];
          count--;
        end
      end
      rsp.entry_count = count[COUNT_W-1:0];
      rsp.is_full     = (count >= limit);
      rsp.is_empty    = (count == 0);
      status_seen[rsp.status]++;
      requests++;
      expected_responses.push_back(rsp);
    endfunction

    // compare one accepted result with the oldest owed response
    function void check_response(logic [STATUS_W-1:0] status, m_tdata_t data);
      response_t got;
      response_t want;
      got.status      = status_e'(status);
      got.found_value = data[31:0];
      got.found_slot  = data[35:32];
      got.entry_count = data[40:36];
      got.is_full     = data[41];
      got.is_empty    = data[42];
      responses++;
      if (expected_responses.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with no request pending: status %0d count %0d",
                   $realtime, got.status, got.entry_count);
        return;
      end
      want = expected_responses.pop_front();
      if (got.status !== want.status || got.found_value !== want.found_value ||
          got.found_slot !== want.found_slot || got.entry_count !== want.entry_count ||
          got.is_full !== want.is_full || got.is_empty !== want.is_empty) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("%0t: mismatch on result %0d", $realtime, responses);
          $display("  expected status %0d value %h slot %0d count %0d full %b empty %b",
                   want.status, want.found_value, want.found_slot, want.entry_count,
                   want.is_full, want.is_empty);
          $display("  actual   status %0d value %h slot %0d count %0d full %b empty %b",
                   got.status, got.found_value, got.found_slot, got.entry_count,
                   got.is_full, got.is_empty);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  cap_t                  cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  s_tdata_t              s_tdata;
  mode_t                 s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  m_tdata_t              m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  table_mirror mirror = new();
  key_t        key_pool[KEY_POOL];
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;

  unsorted_key_value_table_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result receiver with random back-pressure and one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (rst_ni) begin
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) mirror.check_response(m_tuser, m_tdata);
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout: run did not complete in %0d ns", TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one item, called and returning at a falling edge with tvalid held high
  task automatic send_item(mode_t mode, key_t key, value_t value);
    int unsigned gap;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {value, key};
    do @(posedge clk_i); while (!s_tready);
    mirror.apply_request(mode, key, value);
    @(negedge clk_i);
  endtask

  // stop offering and let every owed result come back
  task automatic wait_for_results();
    int unsigned guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (mirror.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // capacity write, only with the table idle
  task automatic write_capacity(cap_t cap);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror.set_capacity(cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random requests, mostly on a small key set so hits and duplicates are common
  task automatic random_burst(int unsigned n, int unsigned insert_pct);
    int unsigned r;
    mode_t       mode;
    key_t        key;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < insert_pct) mode = MODE_INSERT;
      else if (r < insert_pct + (100 - insert_pct) / 2) mode = MODE_REMOVE;
      else if (r < 95) mode = MODE_FIND;
      else mode = MODE_FIND_ALT;
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL-1)];
      else key = $urandom;
      send_item(mode, key, $urandom);
    end
  endtask

  // stimulus
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = MODE_INSERT;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty table: find misses, remove reports empty
    send_item(MODE_FIND, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // extreme keys and values, duplicate, both find codes
    send_item(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(MODE_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_item(MODE_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(MODE_FIND_ALT, 32'h0000_0000, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'h1234_5678, 32'h0000_0000);
    send_item(MODE_FIND, 32'h8000_0001, 32'h0000_0000);
    send_item(MODE_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    // remove from the middle pulls the last entry in, then remove the last slot
    send_item(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(MODE_FIND, 32'hA5A5_A5A5, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'hA5A5_A5A5, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000);
    // capacity of one, then zero with an entry still stored
    write_capacity(5'd1);
    send_item(MODE_INSERT, 32'h0000_0001, 32'hDEAD_BEEF);
    send_item(MODE_INSERT, 32'h0000_0002, 32'h0000_0002);
    write_capacity(5'd0);
    send_item(MODE_INSERT, 32'h0000_0003, 32'h0000_0003);
    send_item(MODE_FIND, 32'h0000_0001, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'h0000_0001, 32'h0000_0000);
    send_item(MODE_INSERT, 32'h0000_0004, 32'h0000_0004);

    // capacity above depth saturates; receiver holds off while items keep coming
    write_capacity(5'd31);
    hold_request = 1'b1;
    random_burst(250, 55);
    // full rate stretch with no idling on either side
    write_capacity(5'd16);
    quiet = 1'b1;
    random_burst(200, 45);
    quiet = 1'b0;
    // lowered below the current count
    write_capacity(5'd3);
    random_burst(200, 50);
    // sender pauses mid-run until all results are back
    write_capacity(5'd17);
    random_burst(100, 60);
    wait_for_results();
    random_burst(100, 60);
    write_capacity(5'd0);
    random_burst(100, 50);
    write_capacity(5'd1);
    random_burst(150, 50);
    write_capacity(5'd9);
    random_burst(300, 50);

    wait_for_results();
    if (mirror.pending() != 0)
      $display("%0d results never arrived", mirror.pending());
    $display("covered %0d requests and %0d results over capacities 16, 0, 1, 3, 9, 17, 31",
             mirror.requests, mirror.responses);
    $display("status mix: ok %0d, full %0d, duplicate %0d, empty %0d, not found %0d",
             mirror.status_seen[STAT_OK], mirror.status_seen[STAT_FULL],
             mirror.status_seen[STAT_DUP], mirror.status_seen[STAT_EMPTY],
             mirror.status_seen[STAT_MISS]);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
